// ===== rtl/sfwc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding frame weighted checksum package
// Shared word width and the record handed from the front stage to the
// accumulator.
// ----------------------------------------------------------------------------
package sfwc_pkg;

   localparam int DATA_W = 32;

   typedef logic [DATA_W-1:0] data_type;

   typedef struct packed {
      logic     start;
      logic     filled;
      logic     full;
      data_type sample;
      data_type oldest;
      data_type product;
   } stage_word_type;

endpackage

// ===== rtl/sfwc_cell.sv =====
// ----------------------------------------------------------------------------
// Sample cell
// One stage of the sample delay line; takes its neighbor's sample on each
// accepted word.
// ----------------------------------------------------------------------------
module sfwc_cell
   import sfwc_pkg::*;
(
   input  logic     clock,
   input  logic     shift_en,
   input  data_type data_in,
   output data_type data_out
);

   data_type sample_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= data_in;
      end
   end

   assign data_out = sample_ff;

endmodule

// ===== rtl/sfwc_accum.sv =====
// ----------------------------------------------------------------------------
// Checksum accumulator
// Keeps the running window sum and weighted checksum and holds the result
// word until the receiver takes it.
// ----------------------------------------------------------------------------
module sfwc_accum
   import sfwc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  stage_word_type in_word,
   output logic           in_ready,
   output logic           out_valid,
   input  logic           out_stall,
   output data_type       out_checksum,
   output logic           out_full
);

   logic     valid_ff;
   logic     valid_in;
   logic     full_ff;
   data_type sum_ff;
   data_type sum_in;
   data_type chk_ff;
   data_type chk_in;
   data_type sum_base;
   data_type chk_base;
   logic     move;

   assign in_ready = !valid_ff || !out_stall;
   assign move     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      sum_base = in_word.start ? '0 : sum_ff;
      chk_base = in_word.start ? '0 : chk_ff;
      chk_in   = chk_base + in_word.product - (in_word.filled ? sum_base : '0);
      sum_in   = sum_base + in_word.sample - (in_word.filled ? in_word.oldest : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         full_ff  <= 1'b0;
         sum_ff   <= '0;
         chk_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (move) begin
            full_ff <= in_word.full;
            sum_ff  <= sum_in;
            chk_ff  <= chk_in;
         end
      end
   end

   assign out_valid    = valid_ff;
   assign out_checksum = chk_ff;
   assign out_full     = full_ff;

   a_start_checksum : assert property (@(posedge clock) disable iff (reset)
      (move && in_word.start) |=> (chk_ff == $past(in_word.product)))
      else $error("checksum after track start is not the first product");

   a_start_sum : assert property (@(posedge clock) disable iff (reset)
      (move && in_word.start) |=> (sum_ff == $past(in_word.sample)))
      else $error("sum after track start is not the first sample");

   a_hold_when_blocked : assert property (@(posedge clock) disable iff (reset)
      !in_ready |=> ($stable(chk_ff) && $stable(sum_ff)))
      else $error("accumulator changed while the result word was held");

endmodule

// ===== rtl/sliding_frame_weighted_checksum_top.sv =====
// ----------------------------------------------------------------------------
// Sliding frame weighted checksum
// Position-weighted checksum over the last WINDOW stereo samples of a track.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one 32-bit stereo sample per word together with
//   req_track_start, which clears the window before that sample is taken.
//   The rsp channel returns one word per request: the weighted checksum of
//   the window after the sample, and rsp_window_full once WINDOW samples of
//   the track have been taken.
//   A word is registered in the multiply stage, then in the accumulator.
//   Throughput is one word per cycle while rsp_stall is low, set by the
//   single multiply stage and the accumulator add; the samples travel
//   through a chain of WINDOW cells that shifts once per accepted word.
//   Reset clears the position, the fill flag, the sums and both pipeline
//   stages; the cell chain is not cleared, and its last cell is used only
//   after WINDOW samples of the current track have passed through.
//   While rsp_stall is high the result word holds, at most one more request
//   is taken into the multiply stage, and then req_stall rises until the
//   receiver takes the result.
// ----------------------------------------------------------------------------
module sliding_frame_weighted_checksum_top
   import sfwc_pkg::*;
#(
   parameter int WINDOW = 588
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_W-1:0]     req_sample,
   input  logic                  req_track_start,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_W-1:0]     rsp_window_checksum,
   output logic                  rsp_window_full
);

   localparam int POS_W = $clog2(WINDOW);
   localparam int WGT_W = $clog2(WINDOW + 1);
   localparam logic [WGT_W-1:0] WIN_C = WGT_W'(WINDOW);

   logic [POS_W-1:0]         pos_ff;
   logic [POS_W-1:0]         pos_in;
   logic [POS_W-1:0]         pos_cur;
   logic                     filled_ff;
   logic                     filled_in;
   logic                     filled_cur;
   logic [WGT_W-1:0]         pos_inc;
   logic [WGT_W-1:0]         weight;
   logic                     wrap;
   logic [DATA_W+WGT_W-1:0]  prod_full;
   logic                     a_valid_ff;
   logic                     a_valid_in;
   stage_word_type           a_word_ff;
   stage_word_type           a_word_in;
   logic                     a_ready;
   logic                     b_ready;
   logic                     accept;
   data_type                 tap [WINDOW];

   assign a_ready   = !a_valid_ff || b_ready;
   assign req_stall = !a_ready;
   assign accept    = req_valid && a_ready;

   genvar gi;
   generate
      for (gi = 0; gi < WINDOW; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            sfwc_cell u_cell (
               .clock    (clock),
               .shift_en (accept),
               .data_in  (req_sample),
               .data_out (tap[gi])
            );
         end else begin : g_body
            sfwc_cell u_cell (
               .clock    (clock),
               .shift_en (accept),
               .data_in  (tap[gi-1]),
               .data_out (tap[gi])
            );
         end
      end
   endgenerate

   always_comb begin
      pos_cur    = req_track_start ? '0 : pos_ff;
      filled_cur = req_track_start ? 1'b0 : filled_ff;
      pos_inc    = WGT_W'(pos_cur) + WGT_W'(1);
      wrap       = (pos_inc == WIN_C);
      pos_in     = wrap ? '0 : pos_inc[POS_W-1:0];
      filled_in  = filled_cur || wrap;
      weight     = filled_cur ? WIN_C : pos_inc;
      prod_full  = {{WGT_W{1'b0}}, req_sample} * {{DATA_W{1'b0}}, weight};

      a_word_in.start   = req_track_start;
      a_word_in.filled  = filled_cur;
      a_word_in.full    = filled_in;
      a_word_in.sample  = req_sample;
      a_word_in.oldest  = tap[WINDOW-1];
      a_word_in.product = prod_full[DATA_W-1:0];

      a_valid_in = accept ? 1'b1 : (b_ready ? 1'b0 : a_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         filled_ff  <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (accept) begin
            pos_ff    <= pos_in;
            filled_ff <= filled_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_word_ff <= a_word_in;
      end
   end

   sfwc_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (a_valid_ff),
      .in_word      (a_word_ff),
      .in_ready     (b_ready),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_checksum (rsp_window_checksum),
      .out_full     (rsp_window_full)
   );

   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      (WGT_W'(pos_ff) < WIN_C))
      else $error("ring position left the window");

   a_start_restart : assert property (@(posedge clock) disable iff (reset)
      (accept && req_track_start) |=> (!filled_ff && pos_ff == POS_W'(1)))
      else $error("track start did not restart the window");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && rsp_valid && rsp_stall))
      else $error("request stalled without a full pipeline");

endmodule

// ===== test/sfwc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding frame weighted checksum checker
// Watches both channels of the block and keeps its own model of the sample
// window. Each accepted request word advances that model. Each accepted
// result word is compared field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module sfwc_checker
   import sfwc_pkg::*;
#(
   parameter int WINDOW = 588
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [DATA_W-1:0] req_sample,
   input  logic              req_track_start,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [DATA_W-1:0] rsp_window_checksum,
   input  logic              rsp_window_full,
   output int                pending_count,
   output int                error_count
);

   typedef struct packed {
      data_type checksum;
      logic     full;
   } window_result_type;

   data_type          frame_ring [WINDOW];
   logic [9:0]        frame_pos;
   logic              frame_full;
   data_type          frame_sum;
   data_type          frame_checksum;
   window_result_type expected_checksums [$];
   int                mismatches = 0;

   assign error_count = mismatches;

   initial begin
      foreach (frame_ring[i]) frame_ring[i] = '0;
   end

   function automatic void clear_frame();
      frame_pos      = '0;
      frame_full     = 1'b0;
      frame_sum      = '0;
      frame_checksum = '0;
   endfunction

   function automatic window_result_type advance_window(data_type sample, logic track_start);
      data_type          oldest;
      window_result_type result;
      if (track_start) clear_frame();
      if (!frame_full) begin
         frame_ring[frame_pos] = sample;
         frame_checksum = frame_checksum + sample * (data_type'(frame_pos) + data_type'(1));
         frame_sum = frame_sum + sample;
      end else begin
         oldest = frame_ring[frame_pos];
         frame_ring[frame_pos] = sample;
         frame_checksum = frame_checksum + sample * data_type'(WINDOW) - frame_sum;
         frame_sum = frame_sum + sample - oldest;
      end
      if (int'(frame_pos) == WINDOW - 1) begin
         frame_pos  = '0;
         frame_full = 1'b1;
      end else begin
         frame_pos = frame_pos + 10'd1;
      end
      result.checksum = frame_checksum;
      result.full     = frame_full;
      return result;
   endfunction

   always @(posedge clock) begin
      window_result_type want;
      if (reset) begin
         clear_frame();
         expected_checksums.delete();
      end else begin
         if (req_valid && !req_stall) begin
            expected_checksums.push_back(advance_window(req_sample, req_track_start));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_checksums.size() == 0) begin
               $error("result word with no request waiting: window_checksum %h window_full %b",
                      rsp_window_checksum, rsp_window_full);
               mismatches++;
            end else begin
               want = expected_checksums.pop_front();
               if (rsp_window_checksum !== want.checksum) begin
                  $error("window_checksum: expected %h, actual %h",
                         want.checksum, rsp_window_checksum);
                  mismatches++;
               end
               if (rsp_window_full !== want.full) begin
                  $error("window_full: expected %b, actual %b", want.full, rsp_window_full);
                  mismatches++;
               end
            end
         end
      end
      pending_count <= expected_checksums.size();
   end

endmodule

// ===== test/tb_sliding_frame_weighted_checksum_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding frame weighted checksum testbench
// Drives stereo sample words in tracks of varied length, with directed
// extremes first and random content after, under random idling on both
// channels and one long receiver hold-off. A separate checker predicts and
// compares every result word; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_sliding_frame_weighted_checksum_top
   import sfwc_pkg::*;
();

   localparam int WINDOW       = 588;
   localparam int RANDOM_WORDS = 800;
   localparam int LONG_HOLD    = 250;
   localparam int CYCLE_LIMIT  = 400000;

   logic     clock           = 1'b0;
   logic     reset           = 1'b1;
   logic     req_valid       = 1'b0;
   logic     req_stall;
   data_type req_sample      = '0;
   logic     req_track_start = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall       = 1'b0;
   data_type rsp_window_checksum;
   logic     rsp_window_full;

   int       pending_words;
   int       failed_checks;
   int       cycle_count     = 0;
   logic     long_hold       = 1'b0;
   logic     hold_done       = 1'b0;
   logic     no_idle         = 1'b0;

   sliding_frame_weighted_checksum_top #(
      .WINDOW(WINDOW)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_track_start    (req_track_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_window_checksum(rsp_window_checksum),
      .rsp_window_full    (rsp_window_full)
   );

   sfwc_checker #(
      .WINDOW(WINDOW)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_track_start    (req_track_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_window_checksum(rsp_window_checksum),
      .rsp_window_full    (rsp_window_full),
      .pending_count      (pending_words),
      .error_count        (failed_checks)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic data_type random_sample();
      data_type value;
      case ($urandom_range(0, 7))
         0: value = '0;
         1: value = '1;
         2: value = data_type'($urandom_range(0, 255));
         3: value = {($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         4: value = {16'($urandom), ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000};
         default: value = $urandom;
      endcase
      return value;
   endfunction

   task automatic offer_word(input data_type sample, input logic track_start);
      int gap;
      req_valid       <= 1'b1;
      req_sample      <= sample;
      req_track_start <= track_start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!(long_hold && !hold_done) && !no_idle && $urandom_range(0, 4) == 0) begin
         req_valid       <= 1'b0;
         req_sample      <= $urandom;
         req_track_start <= 1'b1;
         gap = $urandom_range(1, 15);
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : receiver
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (long_hold && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_done = 1'b1;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            hold = $urandom_range(1, 15);
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : sender
      int sent;
      int track_len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_word(32'h0000_0000, 1'b1);
      offer_word(32'hFFFF_FFFF, 1'b0);
      offer_word(32'h8000_0000, 1'b0);
      offer_word(32'h7FFF_FFFF, 1'b0);
      offer_word(32'hFFFF_0000, 1'b0);
      offer_word(32'h0000_FFFF, 1'b0);
      offer_word(32'h0000_0001, 1'b0);
      offer_word(32'h8000_8000, 1'b0);
      offer_word(32'hFFFF_FFFF, 1'b1);
      offer_word(32'hFFFF_FFFF, 1'b0);
      offer_word(32'hFFFF_FFFF, 1'b0);
      offer_word(32'h0000_0000, 1'b1);
      offer_word(32'h1234_5678, 1'b1);
      offer_word(32'hAAAA_5555, 1'b0);
      offer_word(32'h5555_AAAA, 1'b0);
      offer_word($urandom, 1'b0);
      offer_word($urandom, 1'b0);
      offer_word(32'hFFFF_FFFF, 1'b1);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            0, 1:    track_len = $urandom_range(1, 40);
            2:       track_len = $urandom_range(WINDOW - 1, WINDOW + 1);
            default: track_len = $urandom_range(WINDOW + 1, WINDOW + 300);
         endcase
         for (int i = 0; i < track_len && sent < RANDOM_WORDS; i++) begin
            if (sent == 300) long_hold = 1'b1;
            if (sent == RANDOM_WORDS - 150) no_idle = 1'b1;
            offer_word(random_sample(), i == 0);
            sent++;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failed_checks == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sfwc_pkg.sv
rtl/sfwc_cell.sv
rtl/sfwc_accum.sv
rtl/sliding_frame_weighted_checksum_top.sv
test/sfwc_checker.sv
test/tb_sliding_frame_weighted_checksum_top.sv
